/* rtl/core/ric_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ric_pkg
// Shared types, constants and the Windows-1252 upper table for the INFO parser.
// ============================================================================
package ric_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int HDR_BYTES       = 4;

    localparam logic [15:0] CP_DEFAULT = 16'd0;
    localparam logic [15:0] CP_LATIN1  = 16'd28591;
    localparam logic [15:0] CP_1252    = 16'd1252;
    localparam logic [15:0] CP_UTF8    = 16'd65001;

    localparam logic [7:0] CP1252_LO = 8'h80;
    localparam logic [7:0] CP1252_HI = 8'hA0;

    localparam logic [7:0] ID_CHAR_MIN = 8'h20;
    localparam logic [7:0] ID_CHAR_MAX = 8'h7E;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_CHAR  = 2'd1,
        KIND_END   = 2'd2,
        KIND_STOP  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [31:0] total_length;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] field_id;
        logic [31:0] field_size;
        logic [15:0] char_value;
        logic        last;
    } t_out_item;

    // One queue entry: one or two result beats caused by a single byte.
    typedef struct packed {
        t_kind       kind0;
        t_kind       kind1;
        logic        two;
        logic [7:0]  data_byte;
        logic [31:0] field_id;
        logic [31:0] field_size;
    } t_cmd;

    function automatic logic cp_supported(input logic [15:0] cp);
        return (cp == CP_DEFAULT) || (cp == CP_LATIN1) || (cp == CP_UTF8) ||
               (cp == CP_1252);
    endfunction

    function automatic logic [15:0] cp1252_char(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'h20AC;
            5'd1:    v = 16'h0081;
            5'd2:    v = 16'h201A;
            5'd3:    v = 16'h0192;
            5'd4:    v = 16'h201E;
            5'd5:    v = 16'h2026;
            5'd6:    v = 16'h2020;
            5'd7:    v = 16'h2021;
            5'd8:    v = 16'h02C6;
            5'd9:    v = 16'h2030;
            5'd10:   v = 16'h0160;
            5'd11:   v = 16'h2039;
            5'd12:   v = 16'h0152;
            5'd13:   v = 16'h008D;
            5'd14:   v = 16'h017D;
            5'd15:   v = 16'h008F;
            5'd16:   v = 16'h0090;
            5'd17:   v = 16'h2018;
            5'd18:   v = 16'h2019;
            5'd19:   v = 16'h201C;
            5'd20:   v = 16'h201D;
            5'd21:   v = 16'h2022;
            5'd22:   v = 16'h2013;
            5'd23:   v = 16'h2014;
            5'd24:   v = 16'h02DC;
            5'd25:   v = 16'h2122;
            5'd26:   v = 16'h0161;
            5'd27:   v = 16'h203A;
            5'd28:   v = 16'h0153;
            5'd29:   v = 16'h009D;
            5'd30:   v = 16'h017E;
            default: v = 16'h0178;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/ric_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ric_front
// Byte walker: tracks the chunk phase and queues the result beats of a byte.
// ============================================================================
module ric_front #(
    parameter int LENGTH_BITS = ric_pkg::LENGTH_BITS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  ric_pkg::t_in_item i_in_data,
    input  wire  [15:0]      i_code_page,
    input  wire              i_q_full,
    output logic             o_push,
    output ric_pkg::t_cmd    o_cmd
);
    import ric_pkg::*;

    localparam int L = LENGTH_BITS;

    typedef enum logic [5:0] {
        PH_FORM    = 6'b000001,
        PH_ID      = 6'b000010,
        PH_SIZE    = 6'b000100,
        PH_PAYLOAD = 6'b001000,
        PH_PAD     = 6'b010000,
        PH_STOP    = 6'b100000
    } t_phase;

    t_phase      r_phase, n_phase, e_phase;
    logic [L-1:0] r_pos, n_pos, e_pos;
    logic [L-1:0] r_len, n_len, e_len;
    logic [L-1:0] r_count, n_count, e_count, cnt1, left;
    logic [31:0] r_id, n_id, e_id;
    logic [31:0] r_size, n_size, e_size;
    logic        r_valid, n_valid, e_valid;
    logic        r_nul, n_nul, e_nul;
    logic        accept, first, active, hdr_done;
    logic [7:0]  b;

    function automatic logic id_ok(input logic [31:0] id);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (id[8*i +: 8] < ID_CHAR_MIN || id[8*i +: 8] > ID_CHAR_MAX) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign first      = i_in_data.first_byte;
    assign b          = i_in_data.data_byte;

    always_comb begin
        e_phase = first ? PH_FORM : r_phase;
        e_pos   = first ? '0 : r_pos;
        e_len   = first ? i_in_data.total_length[L-1:0] : r_len;
        e_count = first ? '0 : r_count;
        e_id    = first ? '0 : r_id;
        e_size  = first ? '0 : r_size;
        e_valid = first ? 1'b0 : r_valid;
        e_nul   = first ? 1'b0 : r_nul;

        n_phase = e_phase;
        n_pos   = e_pos;
        n_len   = e_len;
        n_count = e_count;
        n_id    = e_id;
        n_size  = e_size;
        n_valid = e_valid;
        n_nul   = e_nul;

        cnt1     = e_count + L'(1);
        hdr_done = (e_count == L'(HDR_BYTES - 1));
        left     = '0;
        active   = (e_pos < e_len) && (e_phase != PH_STOP);

        o_push          = 1'b0;
        o_cmd.kind0     = KIND_START;
        o_cmd.kind1     = KIND_END;
        o_cmd.two       = 1'b0;
        o_cmd.data_byte = b;
        o_cmd.field_id  = e_id;
        o_cmd.field_size = e_size;

        if (active) begin
            n_pos = e_pos + L'(1);
            case (e_phase)
                PH_FORM: begin
                    if (cnt1 == L'(HDR_BYTES)) begin
                        n_phase = PH_ID;
                        n_count = '0;
                    end else begin
                        n_count = cnt1;
                    end
                end
                PH_ID: begin
                    if (e_count == '0) begin
                        n_id   = {24'h000000, b};
                        n_size = '0;
                    end else begin
                        n_id = {e_id[23:0], b};
                    end
                    n_count = cnt1;
                    if (hdr_done) begin
                        n_valid = id_ok(n_id);
                        n_phase = PH_SIZE;
                        n_count = '0;
                    end
                end
                PH_SIZE: begin
                    n_size  = e_size | (32'(b) << {e_count[1:0], 3'b000});
                    n_count = cnt1;
                    o_cmd.field_size = n_size;
                    if (hdr_done) begin
                        n_count = '0;
                        n_nul   = 1'b0;
                        left    = e_len - n_pos;
                        if (n_size > 32'(left)) begin
                            o_push      = 1'b1;
                            o_cmd.kind0 = KIND_STOP;
                            n_phase     = PH_STOP;
                        end else begin
                            o_push      = e_valid;
                            o_cmd.kind0 = KIND_START;
                            if (n_size == '0) begin
                                o_cmd.two = 1'b1;
                                n_phase   = PH_ID;
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_count = cnt1;
                    if (e_valid && !e_nul && b == 8'h00) begin
                        n_nul = 1'b1;
                    end
                    if (e_valid && !e_nul && b != 8'h00 && cp_supported(i_code_page)) begin
                        o_push      = 1'b1;
                        o_cmd.kind0 = KIND_CHAR;
                        o_cmd.kind1 = KIND_END;
                    end
                    if (32'(cnt1) >= e_size) begin
                        n_count = '0;
                        n_phase = e_size[0] ? PH_PAD : PH_ID;
                        if (e_valid) begin
                            if (o_push) begin
                                o_cmd.two = 1'b1;
                            end else begin
                                o_push      = 1'b1;
                                o_cmd.kind0 = KIND_END;
                            end
                        end
                    end
                end
                PH_PAD: begin
                    n_phase = PH_ID;
                    n_count = '0;
                end
                default: begin
                    n_phase = PH_STOP;
                end
            endcase
        end
        if (!accept) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FORM;
            r_pos   <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_id    <= '0;
            r_size  <= '0;
            r_valid <= 1'b0;
            r_nul   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_count <= n_count;
            r_id    <= n_id;
            r_size  <= n_size;
            r_valid <= n_valid;
            r_nul   <= n_nul;
        end
    end

    a_stop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !first && r_phase == PH_STOP) |-> !o_push)
        else $error("front queued a beat after a stop");

endmodule
`default_nettype wire

/* rtl/core/ric_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ric_queue
// Short register queue of beat commands between the front and the back.
// ============================================================================
module ric_queue #(
    parameter int DEPTH = ric_pkg::QUEUE_DEPTH_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  ric_pkg::t_cmd  i_push_data,
    output logic           o_full,
    input  wire            i_pop,
    output logic           o_valid,
    output ric_pkg::t_cmd  o_head
);
    import ric_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CW'(DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");

endmodule
`default_nettype wire

/* rtl/core/ric_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ric_back
// Expands queued commands into result beats, decodes text, holds the output.
// ============================================================================
module ric_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [15:0]       i_code_page,
    input  wire               i_q_valid,
    input  ric_pkg::t_cmd     i_q_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output ric_pkg::t_out_item o_out_data
);
    import ric_pkg::*;

    logic      r_out_valid;
    t_out_item r_out, n_out;
    logic      r_sub;
    logic      load;
    t_kind     kind;
    logic [15:0] ch;

    assign load  = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_pop = load && (!i_q_head.two || r_sub);
    assign kind  = r_sub ? i_q_head.kind1 : i_q_head.kind0;

    always_comb begin
        ch = {8'h00, i_q_head.data_byte};
        if (i_code_page == CP_1252 &&
            i_q_head.data_byte inside {[CP1252_LO : CP1252_HI - 8'd1]}) begin
            ch = cp1252_char(i_q_head.data_byte[4:0]);
        end
        n_out.kind       = kind;
        n_out.field_id   = i_q_head.field_id;
        n_out.field_size = i_q_head.field_size;
        n_out.char_value = (kind == KIND_CHAR) ? ch : 16'h0000;
        n_out.last       = !i_q_head.two || r_sub;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sub       <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_sub       <= i_q_head.two && !r_sub;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_sub_on_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (i_q_valid && i_q_head.two))
        else $error("second beat pending without a paired entry");

endmodule
`default_nettype wire

/* rtl/core/riff_info_chunk_parser_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// riff_info_chunk_parser_top
// RIFF INFO list body parser: bytes in, field start/text/end beats out.
// ============================================================================
// Input channel: one body byte per beat; first_byte marks byte 0 of a new
// buffer and samples total_length. Output channel: one result per beat,
// last set on the final beat caused by a byte. Config channel: code page,
// always ready, written while the block is idle (a user rule, not enforced
// by the block). Throughput: one byte per cycle while the queue is not full.
// A byte that causes two results (field start with field end, or a character
// with field end) holds the output register for both; the command queue
// absorbs the difference. A byte's command goes into the queue, then into
// the output register. Reset: parse state clears to form type skip with zero
// length, so bytes are dropped until a first_byte; code page clears to the
// default (0); queue and output register empty. When the receiver stalls, the
// queue fills and input ready drops once it holds its full depth of commands.
// ============================================================================
module riff_info_chunk_parser_top #(
    parameter int LENGTH_BITS = ric_pkg::LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = ric_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  ric_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output ric_pkg::t_out_item o_out_data,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [15:0]        i_cfg_data
);
    import ric_pkg::*;

    logic [15:0] r_code_page;
    logic        q_full, q_push, q_pop, q_valid;
    t_cmd        q_in, q_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_page <= CP_DEFAULT;
        end else if (i_cfg_valid) begin
            r_code_page <= i_cfg_data;
        end
    end

    ric_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_code_page (r_code_page),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (q_in)
    );

    ric_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_in),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_head      (q_head)
    );

    ric_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_code_page (r_code_page),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
